// File: hdl/pcc_pkg.sv
// ----------------------------------------------------------------------------
// pcc_pkg : shared types and constants of the particle clean-up classifier
// Command codes, reason codes, register indexes, sequencer states and the arctangent table.
// ----------------------------------------------------------------------------
package pcc_pkg;

  localparam int MAX_SECTORS  = 1024;
  localparam int SEC_W        = $clog2(MAX_SECTORS);
  localparam int CORDIC_STEPS = 20;
  localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_VORTEX = 2'd1,
    CMD_HEAT = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    RSN_KEPT = 2'd0,
    RSN_BODY = 2'd1,
    RSN_SMALL = 2'd2,
    RSN_LAYER = 2'd3
  } reason_t;

  typedef enum logic [1:0] {
    REG_EPS = 2'd0,
    REG_OUTER = 2'd1,
    REG_NSEC = 2'd2,
    REG_BODY = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SQX,
    ST_SQY,
    ST_CLASS,
    ST_CORDIC,
    ST_SCALE,
    ST_RD,
    ST_WAIT,
    ST_WR,
    ST_OUT
  } state_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [15:0] sat_inc(input logic [15:0] c);
    return (c == 16'hFFFF) ? c : c + 16'd1;
  endfunction

endpackage

// File: hdl/particle_cleanup_classifier_core.sv
// ----------------------------------------------------------------------------
// particle_cleanup_classifier_core : clean-up pass particle classifier
// Drops particles inside the body, weak vortices and heat particles in the
// control layer; keeps a per-sector histogram of control-layer hits.
// ----------------------------------------------------------------------------
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/stall   | command, pos, strength, index
//  out_    | output    | out_valid/stall  | drop, reason, sector, counters
//  cfg_    | input     | cfg_valid/ready  | cfg_index, cfg_data
//
//  Vortex, body and kept heat: SQX, SQY, CLASS, then OUT sets the result valid.
//  Read: adds RD and WAIT, one histogram read through the registered port.
//  Layer heat: the CORDIC loop, then SCALE, RD, WAIT and WR before OUT.
//  Start: clears all MAX_SECTORS entries, then OUT; reset clears them and idles.
//  Not ready while a request is in work or its result waits on out_stall;
//  the next request can be taken in the cycle after the result is taken.
// ----------------------------------------------------------------------------
module particle_cleanup_classifier_core (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_command,
  input  logic signed [31:0]       in_pos_x,
  input  logic signed [31:0]       in_pos_y,
  input  logic signed [31:0]       in_strength,
  input  logic [pcc_pkg::SEC_W-1:0] in_sector_index,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_drop,
  output logic [1:0]               out_reason,
  output logic [pcc_pkg::SEC_W-1:0] out_sector,
  output logic [15:0]              out_sector_hits,
  output logic [15:0]              out_inbody_total,
  output logic [15:0]              out_small_total,
  output logic [15:0]              out_heat_total,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [31:0]              cfg_data
);
  import pcc_pkg::*;

  state_t state_r, state_nxt;

  logic [30:0] eps_r;
  logic [31:0] outer_r;
  logic [10:0] nsec_r;
  logic        body_r;

  logic [15:0] hist_mem [MAX_SECTORS];
  logic [15:0] rd_data_r;
  logic [SEC_W-1:0] clr_r;
  logic        boot_r;

  cmd_t        cmd_r;
  logic [31:0] x_r, y_r, g_r;
  logic [31:0] mx_r, my_r;
  logic [63:0] r2_r;
  logic [SEC_W-1:0] idx_r;
  logic signed [33:0] cx_r, cy_r;
  logic [31:0] z_r;
  logic [STEP_W-1:0] step_r;
  logic [10:0] n_r;
  logic [SEC_W-1:0] sec_r;
  logic [15:0] inb_r, sml_r, heat_r;

  logic        drop_r;
  reason_t     reason_r;
  logic [SEC_W-1:0] osec_r;
  logic [15:0] hits_r;
  logic        ovalid_r;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  logic accept;
  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE) || ovalid_r;
  assign cfg_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) begin
        state_nxt = (cmd_t'(in_command) == CMD_START) ? ST_CLEAR : ST_SQX;
      end
      ST_CLEAR:  if (clr_r == SEC_W'(MAX_SECTORS - 1)) state_nxt = boot_r ? ST_IDLE : ST_OUT;
      ST_SQX:    state_nxt = ST_SQY;
      ST_SQY:    state_nxt = ST_CLASS;
      ST_CLASS:  begin
        if (cmd_r == CMD_READ) state_nxt = ST_RD;
        else if (cmd_r == CMD_HEAT && !(body_r && r2_r < 64'h1_0000_0000_0000) && body_r
                 && r2_r < ({32'd0, outer_r} << 24)) state_nxt = ST_CORDIC;
        else state_nxt = ST_OUT;
      end
      ST_CORDIC: if (step_r == STEP_W'(CORDIC_STEPS - 1)) state_nxt = ST_SCALE;
      ST_SCALE:  state_nxt = ST_RD;
      ST_RD:     state_nxt = ST_WAIT;
      ST_WAIT:   state_nxt = (cmd_r == CMD_READ) ? ST_OUT : ST_WR;
      ST_WR:     state_nxt = ST_OUT;
      ST_OUT:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a = mx_r;
    mul_b = mx_r;
    case (state_r)
      ST_SQY:   begin mul_a = my_r; mul_b = my_r; end
      ST_SCALE: begin mul_a = z_r; mul_b = {21'd0, n_r}; end
      default:  begin mul_a = mx_r; mul_b = mx_r; end
    endcase
  end

  logic [31:0] ag;
  logic [33:0] xs, ys;
  logic [63:0] sraw;
  assign ag = g_r[31] ? 32'd0 - g_r : g_r;
  assign xs = cx_r >>> step_r;
  assign ys = cy_r >>> step_r;
  assign sraw = mul_p >> 32;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      boot_r   <= 1'b1;
      ovalid_r <= 1'b0;
      eps_r    <= '0;
      outer_r  <= 32'd16777216;
      nsec_r   <= 11'd256;
      body_r   <= 1'b1;
      inb_r    <= '0;
      sml_r    <= '0;
      heat_r   <= '0;
      cmd_r    <= CMD_START;
    end else begin
      state_r <= state_nxt;
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (reg_idx_t'(cfg_index))
          REG_EPS:   eps_r   <= cfg_data[30:0];
          REG_OUTER: outer_r <= cfg_data;
          REG_NSEC:  nsec_r  <= cfg_data[10:0];
          REG_BODY:  body_r  <= cfg_data[0];
          default:   ;
        endcase
      end
      case (state_r)
        ST_IDLE: if (accept) begin
          cmd_r    <= cmd_t'(in_command);
          x_r      <= in_pos_x;
          y_r      <= in_pos_y;
          g_r      <= in_strength;
          idx_r    <= in_sector_index;
          mx_r     <= in_pos_x[31] ? 32'd0 - in_pos_x : in_pos_x;
          my_r     <= in_pos_y[31] ? 32'd0 - in_pos_y : in_pos_y;
          clr_r    <= '0;
          drop_r   <= 1'b0;
          reason_r <= RSN_KEPT;
          osec_r   <= '0;
          hits_r   <= '0;
          if (cmd_t'(in_command) == CMD_START) begin
            inb_r <= '0; sml_r <= '0; heat_r <= '0;
          end
        end
        ST_CLEAR: begin
          clr_r <= clr_r + SEC_W'(1);
          if (clr_r == SEC_W'(MAX_SECTORS - 1)) boot_r <= 1'b0;
        end
        ST_SQX:   r2_r <= mul_p;
        ST_SQY:   begin
          r2_r <= r2_r + mul_p;
          if (x_r[31]) begin
            cx_r <= -{{2{x_r[31]}}, x_r}; cy_r <= -{{2{y_r[31]}}, y_r};
            z_r <= 32'h8000_0000;
          end else begin
            cx_r <= {{2{x_r[31]}}, x_r}; cy_r <= {{2{y_r[31]}}, y_r};
            z_r <= '0;
          end
          step_r <= '0;
          n_r <= (nsec_r == 11'd0) ? 11'd1 :
                 (nsec_r > 11'(MAX_SECTORS)) ? 11'(MAX_SECTORS) : nsec_r;
        end
        ST_CLASS: begin
          if (cmd_r == CMD_READ) sec_r <= idx_r;
          else if (body_r && r2_r < 64'h1_0000_0000_0000) begin
            drop_r <= 1'b1; reason_r <= RSN_BODY;
            if (cmd_r == CMD_VORTEX) inb_r <= sat_inc(inb_r);
            else heat_r <= sat_inc(heat_r);
          end else if (cmd_r == CMD_VORTEX && ag < {1'b0, eps_r}) begin
            drop_r <= 1'b1; reason_r <= RSN_SMALL;
            sml_r <= sat_inc(sml_r);
          end
        end
        ST_CORDIC: begin
          if (!cy_r[33]) begin
            cx_r <= cx_r + ys; cy_r <= cy_r - xs; z_r <= z_r + atan_turn(5'(step_r));
          end else begin
            cx_r <= cx_r - ys; cy_r <= cy_r + xs; z_r <= z_r - atan_turn(5'(step_r));
          end
          step_r <= step_r + STEP_W'(1);
        end
        ST_SCALE: sec_r <= (sraw[10:0] >= n_r) ? SEC_W'(n_r - 11'd1) : SEC_W'(sraw[10:0]);
        ST_WAIT: begin
          osec_r <= sec_r;
          if (cmd_r == CMD_READ) hits_r <= rd_data_r;
          else begin
            hits_r <= sat_inc(rd_data_r);
            drop_r <= 1'b1; reason_r <= RSN_LAYER;
            heat_r <= sat_inc(heat_r);
          end
        end
        ST_OUT: ovalid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) hist_mem[clr_r] <= '0;
    else if (state_r == ST_WR) hist_mem[sec_r] <= hits_r;
    rd_data_r <= hist_mem[sec_r];
  end

  assign out_valid        = ovalid_r;
  assign out_drop         = drop_r;
  assign out_reason       = reason_r;
  assign out_sector       = osec_r;
  assign out_sector_hits  = hits_r;
  assign out_inbody_total = inb_r;
  assign out_small_total  = sml_r;
  assign out_heat_total   = heat_r;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !accept) else $error("request taken while busy");
  a_out_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |=> (ovalid_r && state_r == ST_IDLE)) else $error("result lost");
  a_layer_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && reason_r == RSN_LAYER) |-> drop_r) else $error("layer without drop");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CORDIC) |-> (step_r < STEP_W'(CORDIC_STEPS))) else $error("step overrun");
`endif

endmodule
